// ===== rtl/tgarle_pkg.sv =====
// Package for the TGA run-length pixel decoder.
// Holds the transaction types, register indexes, decode phases and constants.
`default_nettype none

package tgarle_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned PIXEL_W  = 32;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned BPP_W    = 3;
    localparam int unsigned TOTAL_W  = 25;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = TOTAL_W;

    // Headers at or above this value open a run packet
    localparam logic [BYTE_W-1:0] RUN_THRESHOLD = 8'd128;
    // Run length is header minus this bias
    localparam logic [BYTE_W-1:0] RUN_BIAS      = 8'd127;

    localparam logic [BPP_W-1:0]   BPP_RESET   = 3'd4;
    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 25'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BYTES_PER_PIXEL = 1'b0,
        CFG_TOTAL_PIXELS    = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_PIXEL  = 2'd1,
        PH_STOP   = 2'd2
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              first_of_image;
    } in_item_t;

    // Handshake between input register and decode stage
    typedef struct packed {
        logic valid;
        logic take;
    } stage_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/tgarle_if.sv =====
// Channel interfaces for the TGA run-length pixel decoder.
// Uses tgarle_pkg for field widths.
`default_nettype none

interface tgarle_byte_if;
    logic                              valid;
    logic                              ready;
    logic [tgarle_pkg::BYTE_W-1:0]     data_byte;
    logic                              first_of_image;

    modport source (output valid, output data_byte, output first_of_image, input ready);
    modport sink   (input valid, input data_byte, input first_of_image, output ready);
endinterface

interface tgarle_pixel_if;
    logic                              valid;
    logic                              ready;
    logic [tgarle_pkg::PIXEL_W-1:0]    pixel_value;
    logic [tgarle_pkg::COUNT_W-1:0]    repeat_count;
    logic                              image_done;
    logic                              overflow_error;

    modport source (output valid, output pixel_value, output repeat_count,
                    output image_done, output overflow_error, input ready);
    modport sink   (input valid, input pixel_value, input repeat_count,
                    input image_done, input overflow_error, output ready);
endinterface

`default_nettype wire

// ===== rtl/tgarle_in_reg.sv =====
// Input register of the TGA run-length pixel decoder.
// Depends on tgarle_pkg and tgarle_byte_if.
`default_nettype none

module tgarle_in_reg
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    tgarle_byte_if.sink                 coded,
    input  wire logic                   take,
    output tgarle_pkg::stage_ctl_t      ctl,
    output tgarle_pkg::in_item_t        item
);

    logic                 valid_reg;
    logic                 valid_next;
    tgarle_pkg::in_item_t item_reg;

    // Accept a transaction when empty or when the held one moves on
    assign coded.ready = !valid_reg || take;

    always_comb
    begin
        if (coded.valid && coded.ready)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Load payload on accept
    always_ff @(posedge clk)
    begin
        if (coded.valid && coded.ready)
        begin
            item_reg.data_byte      <= coded.data_byte;
            item_reg.first_of_image <= coded.first_of_image;
        end
    end

    assign ctl.valid = valid_reg;
    assign ctl.take  = take;
    assign item      = item_reg;

endmodule

`default_nettype wire

// ===== rtl/tgarle_core.sv =====
// Decode stage of the TGA run-length pixel decoder: packet state, pixel
// assembly, pixel counting and the result register. Depends on tgarle_pkg.
`default_nettype none

module tgarle_core
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic [tgarle_pkg::BPP_W-1:0]        cfg_bpp,
    input  wire logic [tgarle_pkg::TOTAL_W-1:0]      cfg_total,
    input  wire tgarle_pkg::stage_ctl_t              ctl,
    input  wire tgarle_pkg::in_item_t                item,
    output logic                                     take,
    tgarle_pixel_if.source                           pixel
);

    tgarle_pkg::phase_t                   phase_reg, phase_next, phase_eff;
    logic                                 run_reg, run_next;
    logic [tgarle_pkg::COUNT_W-1:0]       remaining_reg, remaining_next;
    logic [1:0]                           byte_idx_reg, byte_idx_next;
    logic [tgarle_pkg::PIXEL_W-1:0]       asm_reg, asm_next;
    logic [tgarle_pkg::TOTAL_W-1:0]       decoded_reg, decoded_next;

    logic                                 out_valid_reg, out_valid_next;
    logic [tgarle_pkg::PIXEL_W-1:0]       out_value_reg;
    logic [tgarle_pkg::COUNT_W-1:0]       out_count_reg;
    logic                                 out_done_reg;
    logic                                 out_ovf_reg;

    logic [tgarle_pkg::BPP_W-1:0]         bpp_eff;
    logic [tgarle_pkg::TOTAL_W-1:0]       total_eff;
    logic [tgarle_pkg::TOTAL_W-1:0]       decoded_eff;
    logic [tgarle_pkg::TOTAL_W-1:0]       room;
    logic [tgarle_pkg::TOTAL_W-1:0]       decoded_sum;
    logic [tgarle_pkg::COUNT_W-1:0]       run_len;
    logic [tgarle_pkg::COUNT_W-1:0]       fit;
    logic [tgarle_pkg::COUNT_W-1:0]       rest;
    logic [tgarle_pkg::PIXEL_W-1:0]       asm_merged;
    logic                                 last_byte;
    logic                                 reached;
    logic                                 ovf;
    logic                                 done;
    logic                                 emit;

    // Move the held transaction on when the result register is free or draining
    assign take = ctl.valid && (!out_valid_reg || pixel.ready);

    // Restart decoding on the first byte of an image
    assign phase_eff   = item.first_of_image ? tgarle_pkg::PH_HEADER : phase_reg;
    assign decoded_eff = item.first_of_image ? '0 : decoded_reg;

    // Clamp configuration to its usable range
    always_comb
    begin
        case (cfg_bpp)
            3'd0:    bpp_eff = 3'd1;
            3'd1,
            3'd2,
            3'd3,
            3'd4:    bpp_eff = cfg_bpp;
            default: bpp_eff = 3'd4;
        endcase
    end

    assign total_eff = (cfg_total == '0) ? tgarle_pkg::TOTAL_W'(1) : cfg_total;

    // Pixel byte assembly, first byte in the low lane
    assign asm_merged = asm_reg |
        (tgarle_pkg::PIXEL_W'(item.data_byte) << {byte_idx_reg, 3'b000});
    assign last_byte  = ({1'b0, byte_idx_reg} + 3'd1) >= bpp_eff;

    // Count pixels against the total
    assign room        = (total_eff > decoded_eff) ? (total_eff - decoded_eff) : '0;
    assign run_len     = run_reg ? remaining_reg : tgarle_pkg::COUNT_W'(1);
    assign fit         = (room < tgarle_pkg::TOTAL_W'(run_len)) ?
                         room[tgarle_pkg::COUNT_W-1:0] : run_len;
    assign decoded_sum = decoded_eff + tgarle_pkg::TOTAL_W'(fit);
    assign rest        = run_reg ? '0 : (remaining_reg - tgarle_pkg::COUNT_W'(1));
    assign reached     = decoded_sum >= total_eff;
    assign ovf         = (fit < run_len) || (reached && (rest != '0));
    assign done        = ovf || reached;

    assign emit = take && (phase_eff == tgarle_pkg::PH_PIXEL) && last_byte;

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            case (phase_eff)
                tgarle_pkg::PH_HEADER: phase_next = tgarle_pkg::PH_PIXEL;
                tgarle_pkg::PH_PIXEL:
                begin
                    if (!last_byte)
                        phase_next = tgarle_pkg::PH_PIXEL;
                    else if (done)
                        phase_next = tgarle_pkg::PH_STOP;
                    else if (rest == '0)
                        phase_next = tgarle_pkg::PH_HEADER;
                    else
                        phase_next = tgarle_pkg::PH_PIXEL;
                end
                tgarle_pkg::PH_STOP:   phase_next = tgarle_pkg::PH_STOP;
                default:               phase_next = tgarle_pkg::PH_HEADER;
            endcase
        end
    end

    // Packet and pixel state
    always_comb
    begin
        run_next       = run_reg;
        remaining_next = remaining_reg;
        byte_idx_next  = byte_idx_reg;
        asm_next       = asm_reg;
        decoded_next   = decoded_reg;
        if (take)
        begin
            decoded_next = decoded_eff;
            case (phase_eff)
                tgarle_pkg::PH_HEADER:
                begin
                    run_next       = item.data_byte >= tgarle_pkg::RUN_THRESHOLD;
                    remaining_next = (item.data_byte < tgarle_pkg::RUN_THRESHOLD) ?
                                     item.data_byte + tgarle_pkg::COUNT_W'(1) :
                                     item.data_byte - tgarle_pkg::RUN_BIAS;
                    byte_idx_next  = 2'd0;
                    asm_next       = '0;
                end
                tgarle_pkg::PH_PIXEL:
                begin
                    if (last_byte)
                    begin
                        decoded_next   = decoded_sum;
                        remaining_next = rest;
                        byte_idx_next  = 2'd0;
                        asm_next       = '0;
                    end
                    else
                    begin
                        byte_idx_next = byte_idx_reg + 2'd1;
                        asm_next      = asm_merged;
                    end
                end
                default: ;
            endcase
        end
    end

    // Result register valid
    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (pixel.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= tgarle_pkg::PH_HEADER;
            run_reg       <= 1'b0;
            remaining_reg <= '0;
            byte_idx_reg  <= 2'd0;
            asm_reg       <= '0;
            decoded_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            run_reg       <= run_next;
            remaining_reg <= remaining_next;
            byte_idx_reg  <= byte_idx_next;
            asm_reg       <= asm_next;
            decoded_reg   <= decoded_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_value_reg <= asm_merged;
            out_count_reg <= fit;
            out_done_reg  <= done;
            out_ovf_reg   <= ovf;
        end
    end

    assign pixel.valid          = out_valid_reg;
    assign pixel.pixel_value    = out_value_reg;
    assign pixel.repeat_count   = out_count_reg;
    assign pixel.image_done     = out_done_reg;
    assign pixel.overflow_error = out_ovf_reg;

endmodule

`default_nettype wire

// ===== rtl/tga_rle_pixel_decoder.sv =====
// TGA run-length pixel decoder, top level: configuration registers, input
// register and decode stage. Depends on tgarle_pkg, tgarle_if and the stages.
// Throughput: one coded byte per cycle, sustained, with the output ready.
// A pixel result is registered once its last byte leaves the input register.
// Reset: decode state expects a packet header; bytes_per_pixel resets to 4
// and total_pixels to 1.
`default_nettype none

module tga_rle_pixel_decoder
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [tgarle_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tgarle_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    tgarle_byte_if.sink                               coded,
    tgarle_pixel_if.source                            pixel
);

    logic [tgarle_pkg::BPP_W-1:0]    bpp_reg;
    logic [tgarle_pkg::TOTAL_W-1:0]  total_reg;
    logic                            take;
    tgarle_pkg::stage_ctl_t          ctl;
    tgarle_pkg::in_item_t            item;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg   <= tgarle_pkg::BPP_RESET;
            total_reg <= tgarle_pkg::TOTAL_RESET;
        end
        else if (cfg_we)
        begin
            case (tgarle_pkg::cfg_index_t'(cfg_index))
                tgarle_pkg::CFG_BYTES_PER_PIXEL:
                    bpp_reg <= cfg_wdata[tgarle_pkg::BPP_W-1:0];
                tgarle_pkg::CFG_TOTAL_PIXELS:
                    total_reg <= cfg_wdata[tgarle_pkg::TOTAL_W-1:0];
                default: ;
            endcase
        end
    end

    tgarle_in_reg u_in_reg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .coded (coded),
        .take  (take),
        .ctl   (ctl),
        .item  (item)
    );

    tgarle_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_bpp   (bpp_reg),
        .cfg_total (total_reg),
        .ctl       (ctl),
        .item      (item),
        .take      (take),
        .pixel     (pixel)
    );

    // An overflow always ends the image
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel.valid && pixel.overflow_error |-> pixel.image_done)
        else $error("overflow result without image_done");

    // A zero count only comes with an overflow
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel.valid && (pixel.repeat_count == '0) |-> pixel.overflow_error)
        else $error("zero repeat count without overflow");

    // Input stalls only when the result register is full and stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !coded.ready |-> pixel.valid && !pixel.ready)
        else $error("input stalled without output back-pressure");

    // Stage hands an item on only when it holds one
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.take |-> ctl.valid)
        else $error("decode stage took an empty input register");

endmodule

`default_nettype wire
